/* src/rtti_pkg.sv */
`default_nettype none

package rtti_pkg;

   localparam int LOCATIONS = 16384;
   localparam int ADDR_W = $clog2(LOCATIONS);
   localparam int LOC_W = 14;
   localparam int VAL_W = 32;
   localparam int STEP_W = 32;
   localparam int FRAC_W = 17;
   localparam int CSR_DATA_W = 32;
   localparam logic [FRAC_W-1:0] FRAC_ONE = 17'h10000;

   // Width of an unsigned coefficient increment magnitude.
   localparam int INC_W = 42;
   // Wide signed width used before saturation back to 32 bits.
   localparam int WIDE_W = 44;
   localparam logic signed [WIDE_W-1:0] WIDE_MAX = 44'sd2147483647;
   localparam logic signed [WIDE_W-1:0] WIDE_MIN = -44'sd2147483648;

   localparam int OUTQ_DEPTH = 16;

   typedef enum logic [1:0] {
      MODE_SNAPSHOT    = 2'd0,
      MODE_ACCUMULATE  = 2'd1,
      MODE_INTERPOLATE = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      CSR_TIME_STEP       = 2'd0,
      CSR_INTERP_FRACTION = 2'd1
   } csr_index_type;

   typedef struct packed {
      mode_type                  mode;
      logic [LOC_W-1:0]          location;
      logic signed [VAL_W-1:0]   value;
      logic [1:0]                stage;
   } req_type;

   typedef struct packed {
      logic signed [VAL_W-1:0]   interp_value;
      logic [LOC_W-1:0]          out_location;
   } rsp_type;

   typedef struct packed {
      logic signed [VAL_W-1:0]   snap;
      logic signed [VAL_W-1:0]   a1;
      logic signed [VAL_W-1:0]   a2;
      logic signed [VAL_W-1:0]   a3;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic                      valid;
      logic                      write_snap;
      logic                      write_acc;
      logic                      interp;
      logic [LOC_W-1:0]          location;
      logic signed [VAL_W-1:0]   value;
      logic [2:0]                neg;
   } ctl_type;

   typedef struct packed {
      ctl_type                   ctl;
      logic [2:0][INC_W-1:0]     inc;
   } upd_type;

   typedef struct packed {
      logic                      valid;
      logic                      interp;
      logic [LOC_W-1:0]          location;
      entry_type                 entry;
   } hit_type;

   typedef struct packed {
      logic                      valid;
      logic                      push;
      rsp_type                   rsp;
   } fin_type;

   // RK4 dense-output table, scaled by six so that every entry is an integer.
   function automatic logic signed [4:0] rk4_six(input logic [1:0] term,
                                                 input logic [1:0] stage);
      logic signed [4:0] c;
      case ({term, stage})
         4'b00_00: c = 5'sd6;
         4'b01_00: c = -5'sd9;
         4'b01_01: c = 5'sd6;
         4'b01_10: c = 5'sd6;
         4'b01_11: c = -5'sd3;
         4'b10_00: c = 5'sd4;
         4'b10_01: c = -5'sd4;
         4'b10_10: c = -5'sd4;
         4'b10_11: c = 5'sd4;
         default:  c = 5'sd0;
      endcase
      return c;
   endfunction

   function automatic logic signed [VAL_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
      logic signed [VAL_W-1:0] r;
      if (v > WIDE_MAX) begin
         r = 32'sh7FFFFFFF;
      end else if (v < WIDE_MIN) begin
         r = 32'sh80000000;
      end else begin
         r = VAL_W'(v);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

/* src/rtti_ram.sv */
`default_nettype none

module rtti_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // A read of the address being written returns the old contents.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* src/rtti_delta.sv */
`default_nettype none

module rtti_delta (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  rtti_pkg::req_type            req,
   input  logic [rtti_pkg::STEP_W-1:0]  time_step,
   output rtti_pkg::upd_type            upd
);
   import rtti_pkg::*;

   localparam int M_W = VAL_W + STEP_W;
   localparam int PROD_W = M_W + 4;
   localparam int ACC_SHIFT = 25;
   localparam logic [PROD_W-1:0] ROUND_BIAS = PROD_W'(3) << 24;
   localparam int DIGITS = WIDE_W / 4;
   localparam int LO_DIGITS = 5;
   localparam int LO_W = 4 * LO_DIGITS;
   localparam int HI_W = WIDE_W - LO_W;

   // One radix-16 step of a long division by three.
   function automatic logic [5:0] div3_step(input logic [1:0] rem, input logic [3:0] digit);
      logic [5:0]  v;
      logic [12:0] prod;
      logic [3:0]  q;
      logic [5:0]  back;
      v = {rem, digit};
      prod = 13'(v) * 13'd171;
      q = 4'(prod >> 9);
      back = 6'(q) * 6'd3;
      return {q, 2'(v - back)};
   endfunction

   ctl_type                 p1_ctl_ff, p1_ctl_in;
   logic [M_W-1:0]          p1_m_ff, p1_m_in;
   logic [2:0][3:0]         p1_cm_ff, p1_cm_in;

   ctl_type                 p2_ctl_ff;
   logic [2:0][WIDE_W-1:0]  p2_x_ff, p2_x_in;

   ctl_type                 p3_ctl_ff;
   logic [2:0][HI_W-1:0]    p3_qh_ff, p3_qh_in;
   logic [2:0][1:0]         p3_rem_ff, p3_rem_in;
   logic [2:0][LO_W-1:0]    p3_low_ff, p3_low_in;

   upd_type                 upd_ff, upd_in;

   logic                    loc_ok;
   logic [VAL_W-1:0]        vmag;
   logic signed [4:0]       c6;
   logic [1:0]              rem_hi;
   logic [5:0]              step_hi;
   logic [1:0]              rem_lo;
   logic [5:0]              step_lo;
   logic [2:0][LO_W-1:0]    ql;
   logic [WIDE_W-1:0]       whole;

   // Stage one: magnitude of value times dt, sign and scaled table entry per term.
   always_comb begin
      p1_ctl_in = '0;
      p1_ctl_in.valid = accept;
      p1_ctl_in.location = req.location;
      p1_ctl_in.value = req.value;
      loc_ok = 32'(req.location) < 32'(LOCATIONS);
      case (req.mode)
         MODE_SNAPSHOT:    p1_ctl_in.write_snap = accept && loc_ok;
         MODE_ACCUMULATE:  p1_ctl_in.write_acc = accept && loc_ok;
         MODE_INTERPOLATE: p1_ctl_in.interp = accept && loc_ok;
         default:          p1_ctl_in.interp = 1'b0;
      endcase
      vmag = req.value[VAL_W-1] ? VAL_W'(-req.value) : VAL_W'(req.value);
      p1_cm_in = '0;
      for (int k = 0; k < 3; k++) begin
         c6 = rk4_six(2'(k), req.stage);
         p1_ctl_in.neg[k] = req.value[VAL_W-1] ^ c6[4];
         p1_cm_in[k] = c6[4] ? 4'(-c6) : 4'(c6);
      end
      p1_m_in = M_W'(vmag) * M_W'(time_step);
   end

   // Stage two: round(cm * m / (6 * 2^24)) = floor(((cm * m + 3 * 2^24) >> 25) / 3).
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         p2_x_in[k] = WIDE_W'((PROD_W'(p1_m_ff) * PROD_W'(p1_cm_ff[k]) + ROUND_BIAS)
                              >> ACC_SHIFT);
      end
   end

   // Stages three and four: divide by three, upper digits first.
   always_comb begin
      p3_qh_in = '0;
      p3_rem_in = '0;
      p3_low_in = '0;
      for (int k = 0; k < 3; k++) begin
         rem_hi = 2'd0;
         for (int j = DIGITS - 1; j >= LO_DIGITS; j--) begin
            step_hi = div3_step(rem_hi, p2_x_ff[k][4*j +: 4]);
            p3_qh_in[k][4*(j-LO_DIGITS) +: 4] = step_hi[5:2];
            rem_hi = step_hi[1:0];
         end
         p3_rem_in[k] = rem_hi;
         p3_low_in[k] = p2_x_ff[k][LO_W-1:0];
      end
   end

   always_comb begin
      upd_in = '0;
      upd_in.ctl = p3_ctl_ff;
      ql = '0;
      for (int k = 0; k < 3; k++) begin
         rem_lo = p3_rem_ff[k];
         for (int j = LO_DIGITS - 1; j >= 0; j--) begin
            step_lo = div3_step(rem_lo, p3_low_ff[k][4*j +: 4]);
            ql[k][4*j +: 4] = step_lo[5:2];
            rem_lo = step_lo[1:0];
         end
         whole = {p3_qh_ff[k], ql[k]};
         upd_in.inc[k] = INC_W'(whole);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_ctl_ff <= '0;
         p2_ctl_ff <= '0;
         p3_ctl_ff <= '0;
         upd_ff <= '0;
      end else begin
         p1_ctl_ff <= p1_ctl_in;
         p2_ctl_ff <= p1_ctl_ff;
         p3_ctl_ff <= p2_ctl_ff;
         upd_ff <= upd_in;
      end
   end

   always_ff @(posedge clock) begin
      p1_m_ff <= p1_m_in;
      p1_cm_ff <= p1_cm_in;
      p2_x_ff <= p2_x_in;
      p3_qh_ff <= p3_qh_in;
      p3_rem_ff <= p3_rem_in;
      p3_low_ff <= p3_low_in;
   end

   assign upd = upd_ff;

endmodule

`default_nettype wire

/* src/rtti_store.sv */
`default_nettype none

module rtti_store (
   input  logic               clock,
   input  logic               reset,
   input  rtti_pkg::upd_type  upd,
   output rtti_pkg::hit_type  hit
);
   import rtti_pkg::*;

   typedef struct packed {
      logic              valid;
      logic [LOC_W-1:0]  location;
      entry_type         entry;
   } fwd_type;

   function automatic logic signed [VAL_W-1:0] add_inc(input logic signed [VAL_W-1:0] coef,
                                                       input logic [INC_W-1:0] inc,
                                                       input logic neg);
      logic signed [WIDE_W-1:0] sum;
      sum = neg ? WIDE_W'(coef) - WIDE_W'(inc) : WIDE_W'(coef) + WIDE_W'(inc);
      return sat32(sum);
   endfunction

   upd_type             m_ff;
   fwd_type             fwd_ff, fwd_in;
   logic [ENTRY_W-1:0]  rd_data;
   entry_type           old_entry;
   entry_type           new_entry;
   logic                wr_en;
   logic [ADDR_W-1:0]   rd_addr;
   logic [ADDR_W-1:0]   wr_addr;

   assign rd_addr = ADDR_W'(upd.ctl.location);
   assign wr_addr = ADDR_W'(m_ff.ctl.location);

   rtti_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (LOCATIONS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (new_entry),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // The request just ahead may have written this entry in the cycle of our read.
   always_comb begin
      if (fwd_ff.valid && fwd_ff.location == m_ff.ctl.location) begin
         old_entry = fwd_ff.entry;
      end else begin
         old_entry = entry_type'(rd_data);
      end

      new_entry = old_entry;
      if (m_ff.ctl.write_snap) begin
         new_entry.snap = m_ff.ctl.value;
         new_entry.a1 = '0;
         new_entry.a2 = '0;
         new_entry.a3 = '0;
      end else if (m_ff.ctl.write_acc) begin
         new_entry.a1 = add_inc(old_entry.a1, m_ff.inc[0], m_ff.ctl.neg[0]);
         new_entry.a2 = add_inc(old_entry.a2, m_ff.inc[1], m_ff.ctl.neg[1]);
         new_entry.a3 = add_inc(old_entry.a3, m_ff.inc[2], m_ff.ctl.neg[2]);
      end
      wr_en = m_ff.ctl.valid && (m_ff.ctl.write_snap || m_ff.ctl.write_acc);

      fwd_in.valid = wr_en;
      fwd_in.location = m_ff.ctl.location;
      fwd_in.entry = new_entry;

      hit.valid = m_ff.ctl.valid;
      hit.interp = m_ff.ctl.interp;
      hit.location = m_ff.ctl.location;
      hit.entry = old_entry;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_ff <= '0;
         fwd_ff <= '0;
      end else begin
         m_ff <= upd;
         fwd_ff <= fwd_in;
      end
   end

endmodule

`default_nettype wire

/* src/rtti_horner.sv */
`default_nettype none

module rtti_horner (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [rtti_pkg::FRAC_W-1:0]  frac,
   input  rtti_pkg::hit_type            hit,
   output rtti_pkg::fin_type            fin
);
   import rtti_pkg::*;

   localparam int FRAC_SHIFT = 16;
   localparam int SUM_W = 35;
   localparam int P1_W = VAL_W + FRAC_W;
   localparam int P2_W = SUM_W + FRAC_W;
   localparam int R1_W = P1_W + 1 - FRAC_SHIFT;
   localparam int R2_W = P2_W + 1 - FRAC_SHIFT;
   localparam logic [P1_W:0] HALF1 = (P1_W + 1)'(1) << (FRAC_SHIFT - 1);
   localparam logic [P2_W:0] HALF2 = (P2_W + 1)'(1) << (FRAC_SHIFT - 1);

   logic [4:0]                  valid_ff, valid_in;
   logic [4:0]                  interp_ff, interp_in;
   logic [4:0][LOC_W-1:0]       loc_ff, loc_in;

   logic signed [VAL_W-1:0]     i1_snap_ff, i1_a1_ff, i1_a2_ff;
   logic                        i1_neg_ff, i1_neg_in;
   logic [P1_W-1:0]             i1_prod_ff, i1_prod_in;

   logic signed [VAL_W-1:0]     i2_snap_ff, i2_a1_ff;
   logic signed [SUM_W-1:0]     i2_t2_ff, i2_t2_in;

   logic signed [VAL_W-1:0]     i3_snap_ff, i3_a1_ff;
   logic                        i3_neg_ff, i3_neg_in;
   logic [P2_W-1:0]             i3_prod_ff, i3_prod_in;

   logic signed [VAL_W-1:0]     i4_snap_ff;
   logic signed [SUM_W-1:0]     i4_t1_ff, i4_t1_in;

   logic signed [VAL_W-1:0]     i5_snap_ff;
   logic                        i5_neg_ff, i5_neg_in;
   logic [P2_W-1:0]             i5_prod_ff, i5_prod_in;

   logic [VAL_W-1:0]            mag3;
   logic [SUM_W-1:0]            mag2, mag1;
   logic [R1_W-1:0]             r1;
   logic [R2_W-1:0]             r2, r3;
   logic signed [WIDE_W-1:0]    y_wide;

   // Each product rounds to nearest with halves away from zero, on the magnitude.
   always_comb begin
      valid_in = {valid_ff[3:0], hit.valid};
      interp_in = {interp_ff[3:0], hit.interp};
      loc_in = {loc_ff[3:0], hit.location};

      mag3 = hit.entry.a3[VAL_W-1] ? VAL_W'(-hit.entry.a3) : VAL_W'(hit.entry.a3);
      i1_neg_in = hit.entry.a3[VAL_W-1];
      i1_prod_in = P1_W'(mag3) * P1_W'(frac);

      r1 = R1_W'(((P1_W + 1)'(i1_prod_ff) + HALF1) >> FRAC_SHIFT);
      i2_t2_in = i1_neg_ff ? SUM_W'(i1_a2_ff) - SUM_W'(r1) : SUM_W'(i1_a2_ff) + SUM_W'(r1);

      mag2 = i2_t2_ff[SUM_W-1] ? SUM_W'(-i2_t2_ff) : SUM_W'(i2_t2_ff);
      i3_neg_in = i2_t2_ff[SUM_W-1];
      i3_prod_in = P2_W'(mag2) * P2_W'(frac);

      r2 = R2_W'(((P2_W + 1)'(i3_prod_ff) + HALF2) >> FRAC_SHIFT);
      i4_t1_in = i3_neg_ff ? SUM_W'(i3_a1_ff) - SUM_W'(r2) : SUM_W'(i3_a1_ff) + SUM_W'(r2);

      mag1 = i4_t1_ff[SUM_W-1] ? SUM_W'(-i4_t1_ff) : SUM_W'(i4_t1_ff);
      i5_neg_in = i4_t1_ff[SUM_W-1];
      i5_prod_in = P2_W'(mag1) * P2_W'(frac);

      r3 = R2_W'(((P2_W + 1)'(i5_prod_ff) + HALF2) >> FRAC_SHIFT);
      y_wide = i5_neg_ff ? WIDE_W'(i5_snap_ff) - WIDE_W'(r3)
                         : WIDE_W'(i5_snap_ff) + WIDE_W'(r3);

      fin.valid = valid_ff[4];
      fin.push = valid_ff[4] && interp_ff[4];
      fin.rsp.interp_value = sat32(y_wide);
      fin.rsp.out_location = loc_ff[4];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         interp_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         interp_ff <= interp_in;
      end
   end

   always_ff @(posedge clock) begin
      loc_ff <= loc_in;
      i1_snap_ff <= hit.entry.snap;
      i1_a1_ff <= hit.entry.a1;
      i1_a2_ff <= hit.entry.a2;
      i1_neg_ff <= i1_neg_in;
      i1_prod_ff <= i1_prod_in;
      i2_snap_ff <= i1_snap_ff;
      i2_a1_ff <= i1_a1_ff;
      i2_t2_ff <= i2_t2_in;
      i3_snap_ff <= i2_snap_ff;
      i3_a1_ff <= i2_a1_ff;
      i3_neg_ff <= i3_neg_in;
      i3_prod_ff <= i3_prod_in;
      i4_snap_ff <= i3_snap_ff;
      i4_t1_ff <= i4_t1_in;
      i5_snap_ff <= i4_snap_ff;
      i5_neg_ff <= i5_neg_in;
      i5_prod_ff <= i5_prod_in;
   end

endmodule

`default_nettype wire

/* src/rtti_outq.sv */
`default_nettype none

module rtti_outq (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  rtti_pkg::fin_type  fin,
   output logic               full,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rtti_pkg::rsp_type  rsp_payload
);
   import rtti_pkg::*;

   localparam int PTR_W = $clog2(OUTQ_DEPTH);
   localparam int CNT_W = $clog2(OUTQ_DEPTH + 1);

   rsp_type             fifo_ff [OUTQ_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    credit_ff, credit_in;
   logic                pop;
   logic                drop;

   // Every accepted request holds a queue slot until its result is taken, or
   // until it leaves the pipeline without a result, so the queue never overflows.
   always_comb begin
      pop = (count_ff != '0) && !rsp_stall;
      drop = fin.valid && !fin.push;
      wr_ptr_in = wr_ptr_ff + PTR_W'(fin.push);
      rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
      count_in = count_ff + CNT_W'(fin.push) - CNT_W'(pop);
      credit_in = credit_ff + CNT_W'(accept) - CNT_W'(pop) - CNT_W'(drop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
         credit_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
         credit_ff <= credit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fin.push) begin
         fifo_ff[wr_ptr_ff] <= fin.rsp;
      end
   end

   assign full = credit_ff >= CNT_W'(OUTQ_DEPTH);
   assign rsp_valid = count_ff != '0;
   assign rsp_payload = fifo_ff[rd_ptr_ff];

endmodule

`default_nettype wire

/* src/rk4_taylor_time_interpolator_core.sv */
// RK4 dense-output interpolator: each of 16384 locations holds a snapshot value and
// three cubic Taylor coefficients in one 128-bit wide single-port-read memory.
// A snapshot request stores its value and clears the coefficients, an accumulate
// request adds the RK4 weight of its stage times dt times its slope to each
// coefficient (saturating), and an interpolate request returns
// snapshot + f*(a1 + f*(a2 + f*a3)) for the programmed fraction f (values above
// one are clamped to one). An entry must be snapshotted before it is accumulated
// or interpolated. The block takes one request every clock unless req_stall is high, and
// returns a result for every interpolate request it takes: four stages build the
// increment, one reads and writes the memory with forwarding from the write
// just before it, and five evaluate the cubic. A 16-entry result queue lets
// requests keep flowing while results wait; the request side stalls only once
// 16 requests are held in the pipeline and queue together. There is no clearing
// pass after reset. Write time_step and interp_fraction only while idle.
`default_nettype none

module rk4_taylor_time_interpolator_core (
   input  logic                             clock,
   input  logic                             reset,

   input  logic                             req_valid,
   output logic                             req_stall,
   input  rtti_pkg::req_type                req_payload,

   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output rtti_pkg::rsp_type                rsp_payload,

   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  rtti_pkg::csr_index_type          csr_index,
   input  logic [rtti_pkg::CSR_DATA_W-1:0]  csr_data
);
   import rtti_pkg::*;

   logic [STEP_W-1:0]  time_step_ff, time_step_in;
   logic [FRAC_W-1:0]  frac_ff, frac_in;
   logic               accept;
   logic               full;
   upd_type            upd;
   hit_type            hit;
   fin_type            fin;

   assign csr_ready = 1'b1;
   assign req_stall = full;
   assign accept = req_valid && !req_stall;

   always_comb begin
      time_step_in = time_step_ff;
      frac_in = frac_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_TIME_STEP: begin
               time_step_in = STEP_W'(csr_data);
            end
            CSR_INTERP_FRACTION: begin
               frac_in = (csr_data[FRAC_W-1:0] > FRAC_ONE) ? FRAC_ONE : csr_data[FRAC_W-1:0];
            end
            default: begin
               frac_in = frac_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_step_ff <= '0;
         frac_ff <= '0;
      end else begin
         time_step_ff <= time_step_in;
         frac_ff <= frac_in;
      end
   end

   rtti_delta u_delta (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req       (req_payload),
      .time_step (time_step_ff),
      .upd       (upd)
   );

   rtti_store u_store (
      .clock (clock),
      .reset (reset),
      .upd   (upd),
      .hit   (hit)
   );

   rtti_horner u_horner (
      .clock (clock),
      .reset (reset),
      .frac  (frac_ff),
      .hit   (hit),
      .fin   (fin)
   );

   rtti_outq u_outq (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .fin         (fin),
      .full        (full),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

/* test/taylor_check_pkg.sv */
package taylor_check_pkg;
   import rtti_pkg::*;

   localparam longint unsigned ACC_DIV = 64'd6 << 24;
   localparam longint VALUE_MAX = 64'sd2147483647;
   localparam longint VALUE_MIN = -64'sd2147483648;
   // Dense-output weights of the four RK4 stages, times six.
   localparam int RK4_WEIGHT [3][4] = '{'{6, 0, 0, 0}, '{-9, 6, 6, -3}, '{4, -4, -4, 4}};

   class taylor_checker;
      entry_type         entries [LOCATIONS];
      logic [STEP_W-1:0] step_size;
      logic [FRAC_W-1:0] fraction;
      rsp_type           expected_q [$];
      int                mismatches;

      function new();
         step_size = '0;
         fraction = '0;
         mismatches = 0;
      endfunction

      function void set_register(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_TIME_STEP:       step_size = data[STEP_W-1:0];
            CSR_INTERP_FRACTION: fraction = data[FRAC_W-1:0];
            default: ;
         endcase
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function logic signed [VAL_W-1:0] clamp32(longint x);
         if (x > VALUE_MAX) return 32'sh7FFF_FFFF;
         if (x < VALUE_MIN) return 32'sh8000_0000;
         return x[VAL_W-1:0];
      endfunction

      // The increment is w*dt*v / (6*2^24), rounded once, halves away from zero.
      function logic signed [VAL_W-1:0] add_increment(logic signed [VAL_W-1:0] coef, int w,
                                                      logic signed [VAL_W-1:0] v);
         longint unsigned vm, cm, m, q, r, pr, whole, rem;
         longint sv;
         bit neg;
         sv = v;
         neg = (sv < 0) != (w < 0);
         vm = (sv < 0) ? -sv : sv;
         cm = (w < 0) ? -w : w;
         m = vm * step_size;
         q = m / ACC_DIV;
         r = m % ACC_DIV;
         pr = cm * r;
         whole = cm * q + pr / ACC_DIV;
         rem = pr % ACC_DIV;
         if (2 * rem >= ACC_DIV) whole++;
         return clamp32(longint'(coef) + (neg ? -longint'(whole) : longint'(whole)));
      endfunction

      function longint scale_by_fraction(longint t, logic [FRAC_W-1:0] f);
         longint unsigned m, q;
         m = (t < 0) ? -t : t;
         q = (m * f + 64'd32768) >> 16;
         return (t < 0) ? -longint'(q) : longint'(q);
      endfunction

      function rsp_type interpolate(logic [LOC_W-1:0] loc);
         entry_type e;
         logic [FRAC_W-1:0] f;
         longint t2, t1;
         rsp_type res;
         e = entries[loc];
         f = (fraction > FRAC_ONE) ? FRAC_ONE : fraction;
         t2 = longint'($signed(e.a2)) + scale_by_fraction(longint'($signed(e.a3)), f);
         t1 = longint'($signed(e.a1)) + scale_by_fraction(t2, f);
         res.interp_value = clamp32(longint'($signed(e.snap)) + scale_by_fraction(t1, f));
         res.out_location = loc;
         return res;
      endfunction

      function void note_request(req_type r);
         entry_type e;
         e = entries[r.location];
         case (r.mode)
            MODE_SNAPSHOT: begin
               e.snap = r.value;
               e.a1 = '0;
               e.a2 = '0;
               e.a3 = '0;
               entries[r.location] = e;
            end
            MODE_ACCUMULATE: begin
               e.a1 = add_increment(e.a1, RK4_WEIGHT[0][r.stage], r.value);
               e.a2 = add_increment(e.a2, RK4_WEIGHT[1][r.stage], r.value);
               e.a3 = add_increment(e.a3, RK4_WEIGHT[2][r.stage], r.value);
               entries[r.location] = e;
            end
            MODE_INTERPOLATE: expected_q.push_back(interpolate(r.location));
            default: ;
         endcase
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: value %08h location %04h",
                        got.interp_value, got.out_location);
            return;
         end
         want = expected_q.pop_front();
         if (got.interp_value !== want.interp_value) begin
            mismatches++;
            if (mismatches <= 10)
               $display("interp_value mismatch at location %04h: expected %08h, got %08h",
                        want.out_location, want.interp_value, got.interp_value);
         end
         if (got.out_location !== want.out_location) begin
            mismatches++;
            if (mismatches <= 10)
               $display("out_location mismatch: expected %04h, got %04h",
                        want.out_location, got.out_location);
         end
      endfunction
   endclass

endpackage

/* test/tb_top.sv */
module tb_top;
   import rtti_pkg::*;
   import taylor_check_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 40;
   localparam int ITEMS_PER_PHASE = 135;
   localparam int RANDOM_PHASES = 8;
   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam logic [STEP_W-1:0] DT_ONE = 32'h0100_0000;
   localparam logic [LOC_W-1:0] LOC_MID = 14'h2AAA;
   localparam logic [LOC_W-1:0] LOC_ALT = 14'h1555;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_payload = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_payload;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   csr_index_type         csr_index = CSR_TIME_STEP;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   bit                    idle_enable = 1'b1;
   taylor_checker         tracker;
   logic [LOC_W-1:0]      snapped_locs [$];
   bit                    snapped [LOCATIONS];
   int                    sent_items = 0;

   rk4_taylor_time_interpolator_core uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) tracker.check_result(rsp_payload);
         rsp_stall <= idle_enable && ($urandom_range(99) < 16);
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("[rk4_taylor_time_interpolator_core] ERROR");
      $finish;
   end

   task automatic send_request(mode_type m, logic [LOC_W-1:0] loc, logic [VAL_W-1:0] v,
                               logic [1:0] s);
      req_type r;
      r.mode = m;
      r.location = loc;
      r.value = v;
      r.stage = s;
      while (idle_enable && $urandom_range(99) < 16) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_payload <= r;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      tracker.note_request(r);
      if (m == MODE_SNAPSHOT && !snapped[loc]) begin
         snapped[loc] = 1'b1;
         snapped_locs.push_back(loc);
      end
      if (m != mode_type'(MODE_UNUSED)) sent_items++;
   endtask

   // Results only come from interpolate requests, so after the last one the
   // pipeline may still be busy with updates.
   task automatic drain();
      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic program_registers(logic [STEP_W-1:0] dt, logic [CSR_DATA_W-1:0] frac);
      csr_index <= CSR_TIME_STEP;
      csr_data <= dt;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      tracker.set_register(CSR_TIME_STEP, dt);
      csr_index <= CSR_INTERP_FRACTION;
      csr_data <= frac;
      do @(posedge clock); while (!csr_ready);
      tracker.set_register(CSR_INTERP_FRACTION, frac);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [VAL_W-1:0] pick_value();
      case ($urandom_range(4))
         0: return $urandom();
         1: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         2: return $urandom_range(32'h0080_0000) - 32'h0040_0000;
         default: return $urandom_range(32'h0004_0000) - 32'h0002_0000;
      endcase
   endfunction

   function automatic logic [LOC_W-1:0] fresh_location();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         default: return LOC_W'($urandom_range(LOCATIONS - 1));
      endcase
   endfunction

   // Recent entries are favored so that updates to one location land close
   // together in the pipeline.
   function automatic logic [LOC_W-1:0] known_location();
      int n;
      n = snapped_locs.size();
      if (n > 4 && $urandom_range(1)) return snapped_locs[n - 1 - $urandom_range(3)];
      return snapped_locs[$urandom_range(n - 1)];
   endfunction

   task automatic rk4_step(logic [LOC_W-1:0] loc, bit restart);
      int reads;
      reads = $urandom_range(1, 3);
      if (restart) send_request(MODE_SNAPSHOT, loc, pick_value(), 2'($urandom()));
      for (int s = 0; s < 4; s++) send_request(MODE_ACCUMULATE, loc, pick_value(), 2'(s));
      repeat (reads) send_request(MODE_INTERPOLATE, loc, $urandom(), 2'($urandom()));
   endtask

   task automatic random_single();
      logic [LOC_W-1:0] loc;
      int partial;
      case ($urandom_range(9))
         0, 1: send_request(MODE_SNAPSHOT, fresh_location(), pick_value(), 2'($urandom()));
         2, 3, 4: send_request(MODE_ACCUMULATE, known_location(), pick_value(),
                               2'($urandom()));
         5, 6, 7: send_request(MODE_INTERPOLATE, known_location(), $urandom(),
                               2'($urandom()));
         8: begin
            // A step cut short, with stages in any order.
            loc = fresh_location();
            partial = $urandom_range(3);
            send_request(MODE_SNAPSHOT, loc, pick_value(), 2'($urandom()));
            repeat (partial) send_request(MODE_ACCUMULATE, loc, pick_value(), 2'($urandom()));
            send_request(MODE_INTERPOLATE, loc, $urandom(), 2'($urandom()));
         end
         default: send_request(mode_type'(MODE_UNUSED), LOC_W'($urandom()), $urandom(),
                               2'($urandom()));
      endcase
   endtask

   task automatic random_phase(int target);
      int goal;
      logic [LOC_W-1:0] loc;
      goal = sent_items + target;
      while (sent_items < goal) begin
         if ($urandom_range(99) < 65) begin
            loc = $urandom_range(1) ? known_location() : fresh_location();
            rk4_step(loc, !snapped[loc] || $urandom_range(3) != 0);
         end else begin
            random_single();
         end
      end
   endtask

   initial begin
      tracker = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      program_registers(DT_ONE, FRAC_ONE);
      send_request(MODE_SNAPSHOT, '0, 32'h7FFF_FFFF, 2'd0);
      send_request(MODE_SNAPSHOT, '1, 32'h8000_0000, 2'd3);
      send_request(MODE_SNAPSHOT, LOC_MID, 32'h0001_0000, 2'd2);
      send_request(MODE_ACCUMULATE, LOC_MID, 32'h0001_0000, 2'd0);
      send_request(MODE_ACCUMULATE, LOC_MID, 32'hFFFE_0000, 2'd1);
      send_request(MODE_ACCUMULATE, LOC_MID, 32'h0000_8000, 2'd2);
      send_request(MODE_ACCUMULATE, LOC_MID, 32'h0003_0000, 2'd3);
      send_request(MODE_INTERPOLATE, LOC_MID, '0, 2'd0);
      // Drive the stored coefficients and the result into both saturation limits.
      send_request(MODE_ACCUMULATE, '0, 32'h7FFF_FFFF, 2'd0);
      send_request(MODE_INTERPOLATE, '0, '1, 2'd3);
      send_request(MODE_ACCUMULATE, '1, 32'h8000_0000, 2'd0);
      send_request(MODE_ACCUMULATE, '1, 32'h8000_0000, 2'd0);
      send_request(MODE_INTERPOLATE, '1, '0, 2'd1);
      send_request(mode_type'(MODE_UNUSED), LOC_ALT, '1, 2'd3);
      send_request(MODE_INTERPOLATE, LOC_MID, '0, 2'd0);
      drain();

      // Largest step; the fraction register is written above one.
      program_registers('1, '1);
      send_request(MODE_ACCUMULATE, LOC_MID, '1, 2'd3);
      send_request(MODE_ACCUMULATE, LOC_MID, 32'h7FFF_FFFF, 2'd1);
      send_request(MODE_INTERPOLATE, LOC_MID, '0, 2'd2);
      drain();

      program_registers('0, '0);
      send_request(MODE_ACCUMULATE, LOC_MID, 32'h8000_0000, 2'd2);
      send_request(MODE_INTERPOLATE, LOC_MID, '0, 2'd0);
      send_request(MODE_SNAPSHOT, LOC_MID, '1, 2'd1);
      send_request(MODE_INTERPOLATE, LOC_MID, '0, 2'd0);

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         drain();
         case (p)
            0: program_registers(DT_ONE, 32'h0000_8000);
            1: program_registers($urandom_range(32'h0400_0000), $urandom_range(FRAC_ONE));
            2: program_registers('1, FRAC_ONE);
            3: program_registers($urandom_range(32'h0010_0000, 32'h0200_0000),
                                 $urandom_range(FRAC_ONE));
            4: program_registers('0, 32'h1);
            5: program_registers($urandom(), $urandom());
            6: program_registers(DT_ONE, 32'h0001_FFFF);
            default: program_registers($urandom_range(DT_ONE),
                                       {15'($urandom()), 17'h0_FFFF});
         endcase
         idle_enable <= (p != 3);
         random_phase(ITEMS_PER_PHASE);
      end
      drain();

      if (tracker.mismatches == 0 && tracker.pending() == 0)
         $display("[rk4_taylor_time_interpolator_core] OK");
      else
         $display("[rk4_taylor_time_interpolator_core] ERROR");
      $finish;
   end

endmodule
